FILE: rtl/pts_pkg.sv
package pts_pkg;

	// table size and derived index width
	localparam int NUM_TIMERS = 16;
	localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int ID_W       = 4;
	localparam int VAL_W      = 32;
	localparam int ALU_W      = 2 * VAL_W;

	// operation codes
	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_POLL   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXISTS    = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [ID_W-1:0]  timer_id;
		logic [VAL_W-1:0] interval_value;
		logic [VAL_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic                    fired;
		logic [ID_W-1:0]         fired_id;
		logic [VAL_W-1:0]        fired_interval;
		logic signed [VAL_W-1:0] delay_ms;
		logic [1:0]              status;
	} out_item_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [VAL_W-1:0] interval;
		logic [VAL_W-1:0] expiry;
		logic [VAL_W-1:0] order;
	} slot_t;

	// request to and answer from the shared add/subtract unit
	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             borrow;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDID,
		S_EXEC,
		S_SCHED,
		S_SCAN,
		S_SCANEND,
		S_FIRE,
		S_DELAY
	} state_t;

endpackage

FILE: rtl/pts_if.sv
// input channel: one operation per beat
interface pts_in_if;
	import pts_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// result channel: one result per beat
interface pts_out_if;
	import pts_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/pts_mem.sv
module pts_mem (
	input  logic                     clk,
	input  logic                     we,
	input  logic [pts_pkg::IDX_W-1:0] waddr,
	input  pts_pkg::slot_t           wdata,
	input  logic [pts_pkg::IDX_W-1:0] raddr,
	output pts_pkg::slot_t           rdata
);
	import pts_pkg::*;

	slot_t mem_q [NUM_TIMERS];
	slot_t rdata_q;

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: rtl/pts_alu.sv
module pts_alu (
	input  pts_pkg::alu_req_t req,
	output pts_pkg::alu_rsp_t rsp
);
	import pts_pkg::*;

	logic [ALU_W:0] sum;

	// a + b, or a - b as a + ~b + 1; borrow is the missing carry
	always_comb begin
		sum = {1'b0, req.a} + {1'b0, (req.b ^ {ALU_W{req.sub}})} + {{ALU_W{1'b0}}, req.sub};
		rsp.res    = sum[ALU_W-1:0];
		rsp.borrow = req.sub & ~sum[ALU_W];
	end
endmodule

FILE: rtl/periodic_timer_scheduler_top.sv
// channel | dir | beat carries                                  | taken when
// req     | in  | op, timer_id, interval_value, now_ms          | valid & ready
// rsp     | out | fired, fired_id, fired_interval, delay_ms,    | valid & ready
//         |     | status                                        |
//
// One operation at a time; ready is high only between operations.
// Every operation ends with a scan of all N = NUM_TIMERS slots; a poll that fires
// reschedules the winner and scans again. The scan reads one slot per cycle from
// the slot memory (one write port, one read port) into the shared adder.
// Reset (arst_n low) clears the valid bits, the sequence counter and the result flag.
// A result waits in the output register; the next beat may be accepted meanwhile,
// and a finishing operation holds in its last state until that register is free.
module periodic_timer_scheduler_top (
	input logic     clk,
	input logic     arst_n,
	pts_in_if.sink  req,
	pts_out_if.source rsp
);
	import pts_pkg::*;

	state_t           state_q, state_d;
	logic [1:0]       op_q, st_q;
	logic [ID_W-1:0]  id_q;
	logic [VAL_W-1:0] ival_q, now_q;
	logic [IDX_W-1:0] slot_q, cnt_q, idx_s1, bidx_q;
	logic             chk_s1, found_q, pass_q;
	logic [VAL_W-1:0] bexp_q, bord_q, bint_q;
	logic             fired_q;
	logic [ID_W-1:0]  fid_q;
	logic [VAL_W-1:0] fint_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic [VAL_W-1:0] order_q;
	logic             ov_q;
	out_item_t        o_item_q;

	slot_t            rd, wdata;
	logic             we;
	logic [IDX_W-1:0] raddr;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	logic             acc, in_range, slot_vld, take, overdue, fire, out_free, scan_entry;
	logic [VAL_W-1:0] diff, delay;
	logic [VAL_W-1:0] ival_in;

	pts_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (slot_q),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	pts_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// handshake and decode
	assign acc      = req.valid & req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign ival_in  = (req.item.interval_value == '0) ? VAL_W'(1) : req.item.interval_value;
	assign in_range = ({{(32-ID_W){1'b0}}, id_q} < 32'(NUM_TIMERS));
	assign slot_vld = valid_q[slot_q];
	assign take     = chk_s1 & valid_q[idx_s1] & (~found_q | alu_rsp.borrow);
	assign diff     = alu_rsp.res[ALU_W-1:VAL_W];
	assign overdue  = alu_rsp.borrow | (diff == '0);
	assign fire     = found_q & overdue;
	assign out_free = ~ov_q | rsp.ready;
	assign delay    = !found_q ? {VAL_W{1'b1}} :
	                  overdue ? '0 :
	                  diff[VAL_W-1] ? {1'b0, {(VAL_W-1){1'b1}}} : diff;
	assign scan_entry = (state_d == S_SCAN) & (state_q != S_SCAN);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_d = (req.item.op == OP_POLL) ? S_SCAN : S_RDID;
				end
			end
			S_RDID: state_d = S_EXEC;
			S_EXEC: begin
				case (op_q)
					OP_CREATE: state_d = (in_range & ~slot_vld) ? S_SCHED : S_SCAN;
					OP_UPDATE: state_d = (in_range & slot_vld & (rd.interval != ival_q)) ?
					                     S_SCHED : S_SCAN;
					default:   state_d = S_SCAN;
				endcase
			end
			S_SCHED: state_d = S_SCAN;
			S_SCAN: begin
				if (cnt_q == IDX_W'(NUM_TIMERS - 1)) begin
					state_d = S_SCANEND;
				end
			end
			S_SCANEND: state_d = ((op_q == OP_POLL) & ~pass_q) ? S_FIRE : S_DELAY;
			S_FIRE: state_d = fire ? S_SCHED : S_DELAY;
			S_DELAY: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and shared unit controls
	always_comb begin
		raddr       = cnt_q;
		we          = 1'b0;
		wdata       = '{interval: ival_q, expiry: diff, order: order_q};
		alu_req.sub = 1'b1;
		alu_req.a   = {bexp_q, {VAL_W{1'b0}}};
		alu_req.b   = {now_q, {VAL_W{1'b0}}};
		case (state_q)
			S_RDID: raddr = slot_q;
			S_SCHED: begin
				we          = 1'b1;
				alu_req.sub = 1'b0;
				alu_req.a   = {now_q, {VAL_W{1'b0}}};
				alu_req.b   = {ival_q, {VAL_W{1'b0}}};
			end
			S_SCAN, S_SCANEND: begin
				alu_req.a = {rd.expiry, rd.order};
				alu_req.b = {bexp_q, bord_q};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			order_q <= '0;
			ov_q    <= 1'b0;
			chk_s1  <= 1'b0;
			found_q <= 1'b0;
			pass_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			chk_s1  <= (state_q == S_SCAN);
			if (acc) begin
				pass_q <= 1'b0;
			end
			if (state_q == S_EXEC) begin
				if ((op_q == OP_CREATE) & in_range & ~slot_vld) begin
					valid_q[slot_q] <= 1'b1;
				end
				if ((op_q == OP_DELETE) & in_range) begin
					valid_q[slot_q] <= 1'b0;
				end
			end
			if (state_q == S_SCHED) begin
				order_q <= order_q + VAL_W'(1);
			end
			if (state_q == S_FIRE) begin
				pass_q <= 1'b1;
			end
			if (scan_entry) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (state_q == S_SCAN) begin
					cnt_q <= cnt_q + IDX_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if ((state_q == S_DELAY) & out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (acc) begin
			op_q    <= req.item.op;
			id_q    <= req.item.timer_id;
			slot_q  <= IDX_W'(req.item.timer_id);
			ival_q  <= ival_in;
			now_q   <= req.item.now_ms;
			st_q    <= ST_OK;
			fired_q <= 1'b0;
			fid_q   <= '0;
			fint_q  <= '0;
		end
		if (state_q == S_EXEC) begin
			case (op_q)
				OP_CREATE: begin
					if (!in_range) begin
						st_q <= ST_FULL;
					end else if (slot_vld) begin
						st_q <= ST_EXISTS;
					end
				end
				OP_UPDATE, OP_DELETE: begin
					if (!in_range || !slot_vld) begin
						st_q <= ST_NOT_FOUND;
					end
				end
				default: ;
			endcase
		end
		// best so far in (expiry, sequence) order
		if (take) begin
			bexp_q <= rd.expiry;
			bord_q <= rd.order;
			bint_q <= rd.interval;
			bidx_q <= idx_s1;
		end
		// dispatch: reschedule the winner with its own interval
		if ((state_q == S_FIRE) & fire) begin
			fired_q <= 1'b1;
			fid_q   <= ID_W'(bidx_q);
			fint_q  <= bint_q;
			ival_q  <= bint_q;
			slot_q  <= bidx_q;
		end
		if ((state_q == S_DELAY) & out_free) begin
			o_item_q.fired          <= fired_q;
			o_item_q.fired_id       <= fid_q;
			o_item_q.fired_interval <= fint_q;
			o_item_q.delay_ms       <= delay;
			o_item_q.status         <= st_q;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.item  = o_item_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("ready high right after an accepted beat");
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.item.fired |-> rsp.item.status == ST_OK)
		else $error("fired result with non-ok status");
	a_nofire_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.item.fired |-> rsp.item.fired_id == '0 &&
		rsp.item.fired_interval == '0)
		else $error("stale fired fields");
	a_delay_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !rsp.item.delay_ms[VAL_W-1] || rsp.item.delay_ms == '1)
		else $error("delay_ms below -1");
	a_sched_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCHED |-> ival_q != '0)
		else $error("scheduling with a zero interval");
endmodule
